>>> hdl/pcfh_pkg.sv
`timescale 1ns / 1ps

package pcfh_pkg;

    // Frame geometry
    localparam int FRAME_BYTES  = 12;
    localparam int ANSWER_BYTES = 12;
    localparam int FIDX_W       = 4;   // index into frame / answer bytes

    // Protocol characters
    localparam logic [7:0] CH_E      = 8'h45;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_U      = 8'h55;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] FILL_BYTE = 8'hFF;

    // Reset values
    localparam logic [31:0] TACHO_LO_RST     = 32'd20;
    localparam logic [31:0] TACHO_HI_RST     = 32'd600;
    localparam logic [31:0] OVAL_LO_RST      = 32'd150;
    localparam logic [31:0] OVAL_HI_RST      = 32'd150000;
    localparam logic [31:0] TACHO_PERIOD_RST = 32'd300;
    localparam logic [31:0] OVAL_PERIOD_RST  = 32'd150;

    // Input request kinds
    typedef enum logic {
        KIND_BYTE = 1'b0,
        KIND_IDLE = 1'b1
    } kind_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_TACHO_LO = 2'd0,
        REG_TACHO_HI = 2'd1,
        REG_OVAL_LO  = 2'd2,
        REG_OVAL_HI  = 2'd3
    } reg_index_t;

    // Period snapshot handed from front to back
    typedef struct packed {
        logic [31:0] tacho;
        logic [31:0] oval;
    } periods_t;

    // One byte of the answer frame: "ANS\0", tacho BE, oval BE
    function automatic logic [7:0] answer_byte(periods_t p, logic [FIDX_W-1:0] idx);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = CH_A;
            4'd1:    b = CH_N;
            4'd2:    b = CH_S;
            4'd3:    b = CH_NUL;
            4'd4:    b = p.tacho[31:24];
            4'd5:    b = p.tacho[23:16];
            4'd6:    b = p.tacho[15:8];
            4'd7:    b = p.tacho[7:0];
            4'd8:    b = p.oval[31:24];
            4'd9:    b = p.oval[23:16];
            4'd10:   b = p.oval[15:8];
            4'd11:   b = p.oval[7:0];
            default: b = CH_NUL;
        endcase
        return b;
    endfunction

endpackage

>>> hdl/pcfh_front.sv
`timescale 1ns / 1ps

module pcfh_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          rx_byte,
    input  pcfh_pkg::kind_t     kind,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_wr_data,
    output logic                push,
    output pcfh_pkg::periods_t  push_data,
    input  logic                q_full
);
    import pcfh_pkg::*;

    logic [7:0]        frame_reg [FRAME_BYTES];
    logic [7:0]        frame_next [FRAME_BYTES];
    logic [FIDX_W-1:0] count_reg, count_next;
    logic              capturing_reg, capturing_next;
    periods_t          periods_reg, periods_next;
    logic [31:0]       tacho_lo_reg, tacho_hi_reg, oval_lo_reg, oval_hi_reg;

    logic        accept;
    logic        header_ok;
    logic [31:0] tacho_rx, oval_rx;

    // Stall only when the answer queue has no room
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // Frame decode
    assign header_ok = (frame_reg[0] == CH_E) && (frame_reg[1] == CH_M) &&
                       (frame_reg[2] == CH_U) && (frame_reg[3] == CH_NUL);
    assign tacho_rx  = {frame_reg[4], frame_reg[5], frame_reg[6], frame_reg[7]};
    assign oval_rx   = {frame_reg[8], frame_reg[9], frame_reg[10], frame_reg[11]};

    // Capture and classify
    always_comb begin
        frame_next     = frame_reg;
        count_next     = count_reg;
        capturing_next = capturing_reg;
        periods_next   = periods_reg;
        push           = 1'b0;
        if (accept && kind == KIND_BYTE) begin
            if (!capturing_reg) begin
                if (rx_byte == CH_E) begin
                    capturing_next = 1'b1;
                    frame_next[0]  = rx_byte;
                    count_next     = FIDX_W'(1);
                end
            end else if (count_reg < FIDX_W'(FRAME_BYTES)) begin
                frame_next[count_reg] = rx_byte;
                count_next            = count_reg + FIDX_W'(1);
            end
        end else if (accept && kind == KIND_IDLE && capturing_reg) begin
            if (header_ok) begin
                if (tacho_rx >= tacho_lo_reg && tacho_rx <= tacho_hi_reg)
                    periods_next.tacho = tacho_rx;
                if (oval_rx >= oval_lo_reg && oval_rx <= oval_hi_reg)
                    periods_next.oval = oval_rx;
            end
            for (int i = 0; i < FRAME_BYTES; i++) frame_next[i] = FILL_BYTE;
            count_next     = '0;
            capturing_next = 1'b0;
            push           = 1'b1;
        end
    end

    assign push_data = periods_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < FRAME_BYTES; i++) frame_reg[i] <= FILL_BYTE;
            count_reg         <= '0;
            capturing_reg     <= 1'b0;
            periods_reg.tacho <= TACHO_PERIOD_RST;
            periods_reg.oval  <= OVAL_PERIOD_RST;
            tacho_lo_reg      <= TACHO_LO_RST;
            tacho_hi_reg      <= TACHO_HI_RST;
            oval_lo_reg       <= OVAL_LO_RST;
            oval_hi_reg       <= OVAL_HI_RST;
        end else begin
            frame_reg     <= frame_next;
            count_reg     <= count_next;
            capturing_reg <= capturing_next;
            periods_reg   <= periods_next;
            // limit registers
            if (cfg_wr_en) begin
                unique case (reg_index_t'(cfg_index))
                    REG_TACHO_LO: tacho_lo_reg <= cfg_wr_data;
                    REG_TACHO_HI: tacho_hi_reg <= cfg_wr_data;
                    REG_OVAL_LO:  oval_lo_reg  <= cfg_wr_data;
                    REG_OVAL_HI:  oval_hi_reg  <= cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> hdl/pcfh_queue.sv
`timescale 1ns / 1ps

module pcfh_queue #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    // Storage, no reset needed
    always_ff @(posedge aclk) begin
        if (do_wr) mem[wr_ptr_reg] <= wr_data;
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

>>> hdl/pcfh_back.sv
`timescale 1ns / 1ps

module pcfh_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  pcfh_pkg::periods_t q_data,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tlast
);
    import pcfh_pkg::*;

    logic              busy_reg;
    periods_t          ans_reg;
    logic [FIDX_W-1:0] idx_reg;
    logic              m_tvalid_reg, m_tlast_reg;
    logic [7:0]        m_tdata_reg;

    logic out_free, emit, last_byte;

    // Output register is free when empty or being taken this cycle
    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit      = busy_reg && out_free;
    assign last_byte = (idx_reg == FIDX_W'(ANSWER_BYTES - 1));
    assign q_pop     = !q_empty && (!busy_reg || (emit && last_byte));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // serialize one answer byte
            if (emit) begin
                m_tdata_reg  <= answer_byte(ans_reg, idx_reg);
                m_tlast_reg  <= last_byte;
                m_tvalid_reg <= 1'b1;
                idx_reg      <= last_byte ? '0 : idx_reg + FIDX_W'(1);
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            // next answer request from the queue
            if (q_pop) begin
                busy_reg <= 1'b1;
                ans_reg  <= q_data;
            end else if (emit && last_byte) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

>>> hdl/period_command_frame_handler_core.sv
`timescale 1ns / 1ps

// Period command frame handler.
// Slave stream: one request per received UART byte (s_tuser = 0) or per
// receive-line-idle event (s_tuser = 1). A frame opens at an 'E' and keeps
// up to 12 bytes; an idle event closes it. A valid "EMU\0" frame carries
// two big-endian 32-bit periods, each taken only inside its limits.
// Master stream: for every closed frame a 12-byte answer "ANS\0" + tacho
// period + oval period (big-endian), m_tlast on the twelfth byte.
// Config port: cfg_wr_en / cfg_index / cfg_wr_data write the four limit
// registers (tacho low, tacho high, oval low, oval high), one per write.
// Throughput: one input request per cycle while s_tready is high. Each
// answer is sent out byte by byte by the serializer in the back end.
// An accepted idle event's answer passes the queue, the back-end answer
// register and the output register. Answers wait in a QUEUE_DEPTH-entry
// queue; s_tready drops only while that queue is full, i.e. when frames
// close faster than answers go out or the receiver holds m_tready low.
// Reset (aresetn low, synchronous): limits and periods return to their
// defaults, the frame buffer to all 0xFF, queue and output stage empty.
module period_command_frame_handler_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] rx_byte
    input  logic        s_tuser,     // [0] kind
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wr_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // [7:0] tx_byte
    output logic        m_tlast
);
    import pcfh_pkg::*;

    logic     push, q_full, q_empty, q_pop;
    periods_t push_data, q_data;

    pcfh_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .rx_byte     (s_tdata),
        .kind        (kind_t'(s_tuser)),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .push        (push),
        .push_data   (push_data),
        .q_full      (q_full)
    );

    pcfh_queue #(
        .WIDTH ($bits(periods_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (push),
        .wr_data (push_data),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    pcfh_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pcfh_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int STUCK_LIMIT = 4000;  // cycles with no request moving on either side
    localparam int SETTLE_CYCLES = 8;   // idle margin after the last answer has come out

    // One answer byte as it should appear on the master side
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } answer_beat_t;

    // Directed stimulus row; typed rows carry the expected periods fixed in the table
    typedef struct {
        kind_t       kind;
        logic [7:0]  data;
        bit          typed;
        logic [31:0] tacho;
        logic [31:0] oval;
    } dir_row_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'h00;
    logic        s_tuser     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [1:0]  cfg_index   = 2'd0;
    logic [31:0] cfg_wr_data = 32'd0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    // Shadow of the block: limits, periods and the capture buffer
    logic [31:0] tacho_lo  = TACHO_LO_RST;
    logic [31:0] tacho_hi  = TACHO_HI_RST;
    logic [31:0] oval_lo   = OVAL_LO_RST;
    logic [31:0] oval_hi   = OVAL_HI_RST;
    logic [31:0] tacho_per = TACHO_PERIOD_RST;
    logic [31:0] oval_per  = OVAL_PERIOD_RST;
    logic [7:0]  frame_buf [FRAME_BYTES] = '{default: FILL_BYTE};
    int          cap_cnt   = 0;
    bit          cap_on    = 1'b0;

    answer_beat_t answer_q[$];

    int src_gap_pct    = 0;
    int sink_stall_pct = 0;
    int n_items        = 0;
    int n_frames       = 0;
    int n_beats        = 0;
    int n_errors       = 0;
    int n_settings     = 1;
    int stuck_cycles   = 0;

    // A lone 'E' answered with the reset periods, a full in-range frame at
    // both high limits, and a header-only frame whose all-0xFF payload is out of range
    dir_row_t dir_tab [0:22] = '{
        '{KIND_IDLE, 8'h00,  1'b0, 32'd0,   32'd0},
        '{KIND_BYTE, 8'h00,  1'b0, 32'd0,   32'd0},
        '{KIND_BYTE, 8'hFF,  1'b0, 32'd0,   32'd0},
        '{KIND_BYTE, CH_E,   1'b0, 32'd0,   32'd0},
        '{KIND_IDLE, 8'hFF,  1'b1, 32'd300, 32'd150},
        '{KIND_BYTE, CH_E,   1'b0, 32'd0,   32'd0},
        '{KIND_BYTE, CH_M,   1'b0, 32'd0,   32'd0},
        '{KIND_BYTE, CH_U,   1'b0, 32'd0,   32'd0},
        '{KIND_BYTE, CH_NUL, 1'b0, 32'd0,   32'd0},
        '{KIND_BYTE, 8'h00,  1'b0, 32'd0,   32'd0},
        '{KIND_BYTE, 8'h00,  1'b0, 32'd0,   32'd0},
        '{KIND_BYTE, 8'h02,  1'b0, 32'd0,   32'd0},
        '{KIND_BYTE, 8'h58,  1'b0, 32'd0,   32'd0},
        '{KIND_BYTE, 8'h00,  1'b0, 32'd0,   32'd0},
        '{KIND_BYTE, 8'h02,  1'b0, 32'd0,   32'd0},
        '{KIND_BYTE, 8'h49,  1'b0, 32'd0,   32'd0},
        '{KIND_BYTE, 8'hF0,  1'b0, 32'd0,   32'd0},
        '{KIND_IDLE, 8'h00,  1'b1, 32'd600, 32'd150000},
        '{KIND_BYTE, CH_E,   1'b0, 32'd0,   32'd0},
        '{KIND_BYTE, CH_M,   1'b0, 32'd0,   32'd0},
        '{KIND_BYTE, CH_U,   1'b0, 32'd0,   32'd0},
        '{KIND_BYTE, CH_NUL, 1'b0, 32'd0,   32'd0},
        '{KIND_IDLE, 8'h5A,  1'b1, 32'd600, 32'd150000}
    };

    period_command_frame_handler_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Receiver stalls
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Frame capture and period update; returns 1 when a frame closes and an answer is due
    function automatic bit frame_step(kind_t k, logic [7:0] b);
        logic [31:0] t_new;
        logic [31:0] o_new;
        if (k == KIND_BYTE) begin
            if (!cap_on) begin
                if (b == CH_E) begin
                    cap_on       = 1'b1;
                    frame_buf[0] = b;
                    cap_cnt      = 1;
                end
            end else if (cap_cnt < FRAME_BYTES) begin
                frame_buf[cap_cnt] = b;
                cap_cnt++;
            end
            return 1'b0;
        end
        if (!cap_on)
            return 1'b0;
        if (frame_buf[0] == CH_E && frame_buf[1] == CH_M &&
            frame_buf[2] == CH_U && frame_buf[3] == CH_NUL) begin
            t_new = {frame_buf[4], frame_buf[5], frame_buf[6], frame_buf[7]};
            o_new = {frame_buf[8], frame_buf[9], frame_buf[10], frame_buf[11]};
            if (t_new >= tacho_lo && t_new <= tacho_hi)
                tacho_per = t_new;
            if (o_new >= oval_lo && o_new <= oval_hi)
                oval_per = o_new;
        end
        foreach (frame_buf[i])
            frame_buf[i] = FILL_BYTE;
        cap_cnt = 0;
        cap_on  = 1'b0;
        return 1'b1;
    endfunction

    // Queue the 12 answer bytes: "ANS\0", tacho BE, oval BE
    task automatic push_answer(logic [31:0] t_val, logic [31:0] o_val);
        logic [95:0]  frame_bits;
        answer_beat_t beat;
        frame_bits = {CH_A, CH_N, CH_S, CH_NUL, t_val, o_val};
        for (int k = 0; k < ANSWER_BYTES; k++) begin
            beat.tx_byte = frame_bits[95 - 8*k -: 8];
            beat.last    = (k == ANSWER_BYTES - 1);
            answer_q.push_back(beat);
        end
    endtask

    // One request on the slave side, with a random gap ahead of it
    task automatic send_req(kind_t k, logic [7:0] b, bit typed = 1'b0,
                            logic [31:0] t_fix = 32'd0, logic [31:0] o_fix = 32'd0);
        bit answered;
        if ($urandom_range(99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        // only requests that touch the capture state count toward the total
        if (k == KIND_IDLE ? cap_on : (cap_on ? cap_cnt < FRAME_BYTES : b == CH_E))
            n_items++;
        answered = frame_step(k, b);
        if (answered) begin
            n_frames++;
            if (typed)
                push_answer(t_fix, o_fix);
            else
                push_answer(tacho_per, oval_per);
        end
    endtask

    task automatic send_word(logic [31:0] w);
        for (int k = 3; k >= 0; k--)
            send_req(KIND_BYTE, w[8*k +: 8]);
    endtask

    // Period candidates clustered on the limit edges
    function automatic logic [31:0] pick_period(logic [31:0] lo, logic [31:0] hi);
        case ($urandom_range(5))
            0: return lo;
            1: return hi;
            2: return lo - 1;
            3: return hi + 1;
            4: return (lo <= hi) ? $urandom_range(hi, lo) : $urandom;
            default: return $urandom;
        endcase
    endfunction

    // Hold the sender until every outstanding answer has come out
    task automatic pause_for_answers();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (answer_q.size() != 0);
    endtask

    task automatic drain();
        pause_for_answers();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all four limits back to back, enable held high across them
    task automatic write_limits(logic [31:0] t_lo, logic [31:0] t_hi,
                                logic [31:0] o_lo, logic [31:0] o_hi);
        reg_index_t  idx [4];
        logic [31:0] val [4];
        idx = '{REG_TACHO_LO, REG_TACHO_HI, REG_OVAL_LO, REG_OVAL_HI};
        val = '{t_lo, t_hi, o_lo, o_hi};
        for (int k = 0; k < 4; k++) begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= idx[k];
            cfg_wr_data <= val[k];
            @(posedge aclk);
            case (idx[k])
                REG_TACHO_LO: tacho_lo = val[k];
                REG_TACHO_HI: tacho_hi = val[k];
                REG_OVAL_LO:  oval_lo  = val[k];
                REG_OVAL_HI:  oval_hi  = val[k];
            endcase
        end
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    // One random frame: mostly well formed, the rest truncated, broken or noise
    task automatic send_frame();
        int         pick;
        int         n;
        logic [7:0] hdr [4];
        pick = $urandom_range(99);
        hdr  = '{CH_E, CH_M, CH_U, CH_NUL};
        if (pick < 75) begin
            // well formed, or with one header byte spoiled
            if (pick >= 60)
                hdr[$urandom_range(3)] = 8'($urandom);
            foreach (hdr[i])
                send_req(KIND_BYTE, hdr[i]);
            send_word(pick_period(tacho_lo, tacho_hi));
            send_word(pick_period(oval_lo, oval_hi));
            // overlong frame: extra bytes must be dropped
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(1, 4)) send_req(KIND_BYTE, 8'($urandom));
            send_req(KIND_IDLE, 8'($urandom));
        end else if (pick < 88) begin
            // truncated frame, missing bytes read as 0xFF
            n = $urandom_range(0, 10);
            send_req(KIND_BYTE, CH_E);
            for (int k = 1; k <= n; k++)
                send_req(KIND_BYTE, (k < 4 && $urandom_range(1)) ? hdr[k] : 8'($urandom));
            send_req(KIND_IDLE, 8'($urandom));
        end else begin
            // line noise and idles with nothing open
            repeat ($urandom_range(1, 3)) send_req(KIND_BYTE, 8'($urandom));
            send_req(KIND_IDLE, 8'($urandom));
            if ($urandom_range(1))
                send_req(KIND_IDLE, 8'($urandom));
        end
        if ($urandom_range(19) == 0)
            pause_for_answers();
    endtask

    // Answer checker
    always @(posedge aclk) begin
        answer_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_beats++;
            if (answer_q.size() == 0) begin
                if (n_errors < 10)
                    $display("%0t: unexpected answer byte %02h last %0b",
                             $realtime, m_tdata, m_tlast);
                n_errors++;
            end else begin
                want = answer_q.pop_front();
                if (m_tdata !== want.tx_byte || m_tlast !== want.last) begin
                    if (n_errors < 10)
                        $display("%0t: answer byte mismatch: %s %02h last %0b, %s %02h last %0b",
                                 $realtime, "want", want.tx_byte, want.last,
                                 "got", m_tdata, m_tlast);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: nothing moving on either side for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no traffic for %0d cycles, %0d answer bytes outstanding",
                     $realtime, STUCK_LIMIT, answer_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [31:0] lim;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part at reset limits
        src_gap_pct    = 25;
        sink_stall_pct = 56;
        foreach (dir_tab[i])
            send_req(dir_tab[i].kind, dir_tab[i].data, dir_tab[i].typed,
                     dir_tab[i].tacho, dir_tab[i].oval);
        drain();

        // wide open limits: every period passes
        write_limits(32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        while (n_items < 86)
            send_frame();
        drain();

        // tacho low above high, oval pinned to a single value
        src_gap_pct    = 56;
        sink_stall_pct = 25;
        lim = $urandom;
        write_limits(32'hFFFF_FFFF, 32'd0, lim, lim);
        while (n_items < 148)
            send_frame();
        drain();

        // random windows, no idling on either side
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        lim = $urandom_range(0, 1000);
        write_limits(lim, lim + $urandom_range(0, 2000), OVAL_LO_RST, OVAL_HI_RST);
        while (n_items < 180)
            send_frame();
        drain();
        lim = $urandom;
        write_limits(TACHO_LO_RST, TACHO_HI_RST, lim,
                     $urandom_range(3) == 0 ? lim - 1 : lim + $urandom_range(0, 100000));
        while (n_items < 212)
            send_frame();
        drain();

        $display("Run covered %0d counted requests, %0d frames answered,",
                 n_items, n_frames);
        $display("%0d answer bytes checked over %0d limit settings, idling swapped then off.",
                 n_beats, n_settings);
        if (n_errors == 0 && answer_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
hdl/pcfh_pkg.sv
hdl/pcfh_front.sv
hdl/pcfh_queue.sv
hdl/pcfh_back.sv
hdl/period_command_frame_handler_core.sv
dv/tb_top.sv
